/* hdl/s2dec_pkg.sv */
// Shared types, constants and helpers for the signed integer to decimal ASCII converter.
// Stands alone; the top level signed_int_to_decimal_ascii refers to it by scoped names.
package s2dec_pkg;

  // Sequencer states of the converter.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  typedef logic [3:0] bcd_digit_t;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // Double-dabble correction: a digit of five or more gets three added before the shift.
  function automatic bcd_digit_t add3(input bcd_digit_t d);
    bcd_digit_t r;
    if (d >= 4'd5) begin
      r = d + 4'd3;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

/* hdl/signed_int_to_decimal_ascii.sv */
// Top level of the signed integer to decimal ASCII converter.
// Depends on s2dec_pkg for the state type, the ASCII constants and the BCD correction.
//
// One input transaction carries a signed two's complement integer of DATA_WIDTH bits; the
// block answers with its decimal text, one ASCII character per output transaction, most
// significant first: a '-' for negative values, then the digits without leading zeros
// (zero gives a single '0'), with last_char_o high on the final character. The magnitude is
// taken as unsigned, so the most negative value prints in full. The conversion is a
// double-dabble loop: one shared bank of add-3 correctors and a one-bit shift run once per
// input bit. A leading-zero scan then drops one zero digit per cycle, and each character
// is loaded into the output register while the output is not stalled. Leading zeros and
// digits always fill the ten digit positions at the default width of 32 bits. in_stall_o
// stays high from acceptance until the last character has been placed in the output
// register; the next number is accepted while that character still waits to be taken.
module signed_int_to_decimal_ascii #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   text_char_o,
  output logic                         last_char_o
);

  // Decimal digits needed for any value below 2^DATA_WIDTH (1233/4096 approximates log10 2).
  localparam int NumDigits = ((DATA_WIDTH * 1233) >> 12) + 1;
  localparam int BcdWidth  = 4 * NumDigits;
  localparam int BitCntW   = $clog2(DATA_WIDTH + 1);
  localparam int DigCntW   = $clog2(NumDigits + 1);

  s2dec_pkg::state_e state_q, state_d;

  logic [DATA_WIDTH-1:0] mag_q, mag_d;
  logic [BcdWidth-1:0]   bcd_q, bcd_d;
  logic [BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]    dig_cnt_q, dig_cnt_d;
  logic                  neg_q, neg_d;

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;

  logic                  in_accept;
  logic                  out_free;
  logic                  out_load;
  logic [DATA_WIDTH-1:0] value_u;
  logic [BcdWidth-1:0]   bcd_adj;
  s2dec_pkg::bcd_digit_t top_digit;

  assign in_stall_o  = (state_q != s2dec_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = out_free && ((state_q == s2dec_pkg::ST_SIGN) ||
                                    (state_q == s2dec_pkg::ST_DIGIT));
  assign value_u     = $unsigned(value_i);
  assign top_digit   = bcd_q[BcdWidth-1 -: 4];

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

  // The shared correction bank: every BCD digit gets its add-3 step in parallel.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = s2dec_pkg::add3(bcd_q[4*i +: 4]);
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      s2dec_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = s2dec_pkg::ST_CONVERT;
        end
      end
      s2dec_pkg::ST_CONVERT: begin
        if (bit_cnt_q == BitCntW'(1)) begin
          state_d = s2dec_pkg::ST_SKIP;
        end
      end
      s2dec_pkg::ST_SKIP: begin
        if ((top_digit != 4'd0) || (dig_cnt_q == DigCntW'(1))) begin
          state_d = neg_q ? s2dec_pkg::ST_SIGN : s2dec_pkg::ST_DIGIT;
        end
      end
      s2dec_pkg::ST_SIGN: begin
        if (out_free) begin
          state_d = s2dec_pkg::ST_DIGIT;
        end
      end
      s2dec_pkg::ST_DIGIT: begin
        if (out_free && (dig_cnt_q == DigCntW'(1))) begin
          state_d = s2dec_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = s2dec_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and output register updates for each state.
  always_comb begin
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    neg_d       = neg_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      s2dec_pkg::ST_IDLE: begin
        if (in_accept) begin
          neg_d     = value_u[DATA_WIDTH-1];
          mag_d     = value_u[DATA_WIDTH-1] ? ((~value_u) + DATA_WIDTH'(1)) : value_u;
          bcd_d     = '0;
          bit_cnt_d = BitCntW'(DATA_WIDTH);
        end
      end
      s2dec_pkg::ST_CONVERT: begin
        bcd_d     = {bcd_adj[BcdWidth-2:0], mag_q[DATA_WIDTH-1]};
        mag_d     = {mag_q[DATA_WIDTH-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - BitCntW'(1);
        dig_cnt_d = DigCntW'(NumDigits);
      end
      s2dec_pkg::ST_SKIP: begin
        if ((top_digit == 4'd0) && (dig_cnt_q != DigCntW'(1))) begin
          bcd_d     = {bcd_q[BcdWidth-5:0], 4'd0};
          dig_cnt_d = dig_cnt_q - DigCntW'(1);
        end
      end
      s2dec_pkg::ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = s2dec_pkg::ASCII_MINUS;
          last_d      = 1'b0;
        end
      end
      s2dec_pkg::ST_DIGIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = s2dec_pkg::ASCII_ZERO + {4'd0, top_digit};
          last_d      = (dig_cnt_q == DigCntW'(1));
          bcd_d       = {bcd_q[BcdWidth-5:0], 4'd0};
          dig_cnt_d   = dig_cnt_q - DigCntW'(1);
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= s2dec_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    bcd_q     <= bcd_d;
    bit_cnt_q <= bit_cnt_d;
    dig_cnt_q <= dig_cnt_d;
    neg_q     <= neg_d;
    char_q    <= char_d;
    last_q    <= last_d;
  end

  // An accepted number always starts the conversion loop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == s2dec_pkg::ST_CONVERT))
    else $error("accepted transaction did not start conversion");

  // The sign is only emitted for negative numbers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == s2dec_pkg::ST_SIGN) |-> neg_q)
    else $error("sign state reached for a non-negative number");

  // Loading the final character ends the number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_d) |=> (state_q == s2dec_pkg::ST_IDLE))
    else $error("final character loaded but sequencer not idle");

  // Emitted characters are a minus sign or a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((text_char_o == s2dec_pkg::ASCII_MINUS) ||
                     ((text_char_o >= s2dec_pkg::ASCII_ZERO) &&
                      (text_char_o <= s2dec_pkg::ASCII_NINE))))
    else $error("emitted character is not a sign or digit");

  // The digit counter never runs out while digits are still being emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == s2dec_pkg::ST_DIGIT) |-> (dig_cnt_q != '0))
    else $error("digit counter empty in digit state");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for signed_int_to_decimal_ascii, the signed integer to ASCII converter.
// Depends on the RTL top level and on s2dec_pkg for the ASCII character constants.
`timescale 1ns / 100ps

module testbench;

  // The block is checked at its default width of 32 bits.
  localparam int VALUE_BITS = 32;
  // Longest text is a sign and ten digits.
  localparam int MAX_TEXT = 11;
  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM = 300;
  // Cycles left after the last character, enough for any conversion still in flight.
  localparam int DRAIN_CYCLES = 80;
  // A run is 320 items, so 5 ms leaves ample margin.
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int MAX_REPORTS = 10;

  // One character of expected decimal text.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ascii_out_t;

  // Directed stimulus row. Where has_text is set, the expected text is typed in as a
  // right-aligned string; otherwise the predictor works it out.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  has_text;
    logic [8*MAX_TEXT-1:0] text;
  } dir_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic signed [VALUE_BITS-1:0] value_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [7:0]                   text_char_o;
  logic                         last_char_o;

  // Characters still owed by the block, oldest first.
  ascii_out_t pending_chars[$];
  int         mismatch_count = 0;
  // While set, neither side inserts idle cycles.
  bit         steady_flow = 1'b0;

  dir_row_t dir_rows [NUM_DIRECTED];

  signed_int_to_decimal_ascii #(
    .DATA_WIDTH(VALUE_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the decimal text of one value and queues it character by character.
  // The magnitude is taken as unsigned, so negating the most negative value stays correct.
  function automatic void predict_decimal_text(input logic [VALUE_BITS-1:0] value);
    logic                  negative;
    logic [VALUE_BITS-1:0] magnitude;
    logic [7:0]            digit_buf [MAX_TEXT];
    int                    num_digits;
    negative = value[VALUE_BITS-1];
    magnitude = negative ? (~value + 1'b1) : value;
    num_digits = 0;
    // Digits come out least significant first; zero still yields one digit.
    do begin
      digit_buf[num_digits] = s2dec_pkg::ASCII_ZERO + 8'(magnitude % 10);
      num_digits++;
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (negative) begin
      pending_chars.push_back('{ch: s2dec_pkg::ASCII_MINUS, last: 1'b0});
    end
    for (int k = num_digits - 1; k >= 0; k--) begin
      pending_chars.push_back('{ch: digit_buf[k], last: 1'b0});
    end
    pending_chars[pending_chars.size() - 1].last = 1'b1;
  endfunction

  // Offers one value to the block after a random gap (none during steady flow) and waits
  // until it is taken. The expected text is queued at the edge of acceptance, from the typed string when given.
  task automatic drive_value(input logic [VALUE_BITS-1:0] value, input logic has_text,
                             input logic [8*MAX_TEXT-1:0] text);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    if (has_text) begin
      for (int b = MAX_TEXT - 1; b >= 0; b--) begin
        if (text[8*b +: 8] != 8'h00) begin
          pending_chars.push_back('{ch: text[8*b +: 8], last: 1'b0});
        end
      end
      pending_chars[pending_chars.size() - 1].last = 1'b1;
    end else begin
      predict_decimal_text(value);
    end
  endtask

  // Holds the input idle until every queued character has come out.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // Output stall: after each accepted character the receiver may stall at random, except during steady flow.
  always @(posedge clk_i) begin : stall_gen
    int stall_left;
    int draw;
    if (!rst_ni) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) begin
        out_stall_i <= 1'b0;
      end
    end else if (out_valid_o && !out_stall_i) begin
      draw = steady_flow ? 0 : $urandom_range(0, 5);
      if (draw > 0) begin
        out_stall_i <= 1'b1;
        stall_left = draw;
      end
    end
  end

  // Each accepted character is compared with the oldest expectation.
  always @(posedge clk_i) begin : char_check
    ascii_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: unexpected character 0x%02h last=%0b", $realtime, text_char_o,
                   last_char_o);
        end
      end else begin
        want = pending_chars.pop_front();
        if (text_char_o !== want.ch) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: text_char expected 0x%02h got 0x%02h", $realtime, want.ch,
                     text_char_o);
          end
        end
        if (last_char_o !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: last_char expected %0b got %0b", $realtime, want.last,
                     last_char_o);
          end
        end
      end
    end
  end

  // Stimulus: a directed table first, then random values, then the final verdict.
  initial begin : stimulus
    logic [VALUE_BITS-1:0] rand_value;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;

    // Extremes, digit-count boundaries and the sign cases. Expected text is typed in where
    // it is obvious; the remaining rows go through the predictor.
    dir_rows = '{
      '{32'h0000_0000, 1'b1, "0"},            // zero gives a single character
      '{32'h0000_0001, 1'b1, "1"},
      '{32'hFFFF_FFFF, 1'b1, "-1"},
      '{32'h0000_0009, 1'b1, "9"},
      '{32'h0000_000A, 1'b1, "10"},
      '{32'hFFFF_FFF7, 1'b1, "-9"},
      '{32'hFFFF_FFF6, 1'b1, "-10"},
      '{32'h7FFF_FFFF, 1'b1, "2147483647"},   // largest positive
      '{32'h8000_0000, 1'b1, "-2147483648"},  // most negative, magnitude overflows signed
      '{32'h8000_0001, 1'b1, "-2147483647"},
      '{32'h3B9A_CA00, 1'b1, "1000000000"},
      '{32'hC465_3600, 1'b1, "-1000000000"},
      '{32'h7FFF_FFFE, 1'b0, '0},
      '{32'h0000_0063, 1'b0, '0},
      '{32'h0000_0064, 1'b0, '0},
      '{32'h3B9A_C9FF, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h0000_3039, 1'b0, '0},
      '{32'hC521_974F, 1'b0, '0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      drive_value(dir_rows[i].value, dir_rows[i].has_text, dir_rows[i].text);
    end
    // Let the directed part drain completely before the random part starts.
    wait_until_drained();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // A stretch with no idling on either side.
      steady_flow = (n >= 60 && n < 100);
      // Mix of full-width values, short numbers, every magnitude scale and values near
      // the extremes, so that all text lengths and both signs turn up often.
      case ($urandom_range(0, 3))
        0: rand_value = $urandom;
        1: rand_value = $urandom_range(0, 99);
        2: rand_value = $urandom >> $urandom_range(0, 31);
        default: begin
          if ($urandom_range(0, 1) == 1) begin
            rand_value = 32'h8000_0000 + $urandom_range(0, 3);
          end else begin
            rand_value = 32'h7FFF_FFFF - $urandom_range(0, 3);
          end
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        rand_value = ~rand_value + 1'b1;
      end
      drive_value(rand_value, 1'b0, '0);
      // Midway, the sender holds off until the block has caught up.
      if (n == NUM_RANDOM / 2) begin
        wait_until_drained();
      end
    end
    steady_flow = 1'b0;

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("timeout with %0d characters outstanding", pending_chars.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
